// ----- design/amu_pkg.sv -----
package amu_pkg;

  // operation codes; bit 0 selects accumulate, bit 2 selects signed long forms
  localparam logic [2:0] OP_MUL   = 3'd0;
  localparam logic [2:0] OP_MLA   = 3'd1;
  localparam logic [2:0] OP_UMULL = 3'd2;
  localparam logic [2:0] OP_UMLAL = 3'd3;
  localparam logic [2:0] OP_SMULL = 3'd4;
  localparam logic [2:0] OP_SMLAL = 3'd5;

  localparam int unsigned OpAccBit    = 0;
  localparam int unsigned OpSignedBit = 2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] multiplicand;
    logic [31:0] multiplier;
    logic [31:0] accumulate_low;
    logic [31:0] accumulate_high;
    logic        set_flags;
  } req_t;

  typedef struct packed {
    logic [31:0] result_low;
    logic [31:0] result_high;
    logic        zero_flag;
    logic        negative_flag;
    logic        flags_written;
    logic [2:0]  internal_cycles;
  } rsp_t;

  // what travels beside the product through the multiply stages
  typedef struct packed {
    logic        is_long;
    logic        set_flags;
    logic [63:0] addend;
    logic [2:0]  cycles;
  } side_t;

endpackage

// ----- design/amu_mul_pipe.sv -----
module amu_mul_pipe
  import amu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        signed_i,
  input  side_t       side_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [63:0] prod_o,
  output side_t       side_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;
  logic [31:0] corr_d, corr_q;
  side_t       side1_q, side2_q, side3_q;

  logic [32:0] mid_d, mid_q;
  logic [31:0] hi_d, hi_q, lo_q;

  logic [63:0] prod_d, prod_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // signed product = unsigned product - (sign corrections << 32)
  assign corr_d = ((signed_i && a_i[31]) ? b_i : 32'd0)
                + ((signed_i && b_i[31]) ? a_i : 32'd0);

  assign mid_d  = {1'b0, pp_lh_q} + {1'b0, pp_hl_q};
  assign hi_d   = pp_hh_q - corr_q;
  assign prod_d = {hi_q, lo_q} + {15'd0, mid_q, 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      pp_ll_q <= {16'd0, a_i[15:0]}  * {16'd0, b_i[15:0]};
      pp_lh_q <= {16'd0, a_i[15:0]}  * {16'd0, b_i[31:16]};
      pp_hl_q <= {16'd0, a_i[31:16]} * {16'd0, b_i[15:0]};
      pp_hh_q <= {16'd0, a_i[31:16]} * {16'd0, b_i[31:16]};
      corr_q  <= corr_d;
      side1_q <= side_i;
    end
    if (rdy2 && v1_q) begin
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      lo_q    <= pp_ll_q;
      side2_q <= side1_q;
    end
    if (rdy3 && v2_q) begin
      prod_q  <= prod_d;
      side3_q <= side2_q;
    end
  end

  assign valid_o = v3_q;
  assign prod_o  = prod_q;
  assign side_o  = side3_q;

  // a stalled stage never drops its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !ready_i |=> v3_q)
    else $error("stage 3 lost an item while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !rdy2 |=> v2_q && $stable(hi_q))
    else $error("stage 2 changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && !ready_i |-> !ready_o)
    else $error("full pipeline took a request");

endmodule

// ----- design/arm_multiply_unit.sv -----
// channel | signals                         | payload
// in      | in_valid_i / in_ready_o         | in_req_i  (req_t)
// out     | out_valid_o / out_ready_i       | out_rsp_o (rsp_t)
//
// one request per cycle while the pipeline is not full; each request
// runs three multiply stages: 16x16 partial products, partial sums, product;
// then accumulate and flags into the output register
// reset clears the valid bits only; payload registers are not reset
// a stall at the output backs up stage by stage; empty stages keep accepting
module arm_multiply_unit
  import amu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic        acc, is_long, is_signed, et_signed;
  logic [2:0]  m_cnt;
  side_t       side_in, side_out;
  logic        pipe_valid, pipe_ready;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [31:0] rs;
  rsp_t        rsp_d, rsp_q;
  logic        out_valid_q;
  logic        long_q;

  assign acc       = in_req_i.operation[OpAccBit];
  assign is_long   = in_req_i.operation >= OP_UMULL;
  assign is_signed = is_long && in_req_i.operation[OpSignedBit];
  assign et_signed = !is_long || in_req_i.operation[OpSignedBit];
  assign rs        = in_req_i.multiplier;

  // early termination on the upper multiplier bytes
  always_comb begin
    if (rs[31:8] == 24'd0 || (et_signed && rs[31:8] == 24'hFFFFFF)) begin
      m_cnt = 3'd1;
    end else if (rs[31:16] == 16'd0 || (et_signed && rs[31:16] == 16'hFFFF)) begin
      m_cnt = 3'd2;
    end else if (rs[31:24] == 8'd0 || (et_signed && rs[31:24] == 8'hFF)) begin
      m_cnt = 3'd3;
    end else begin
      m_cnt = 3'd4;
    end
  end

  always_comb begin
    side_in.is_long   = is_long;
    side_in.set_flags = in_req_i.set_flags;
    side_in.cycles    = m_cnt + {2'd0, acc} + {2'd0, is_long};
    if (!acc) begin
      side_in.addend = 64'd0;
    end else if (is_long) begin
      side_in.addend = {in_req_i.accumulate_high, in_req_i.accumulate_low};
    end else begin
      side_in.addend = {32'd0, in_req_i.accumulate_low};
    end
  end

  amu_mul_pipe u_mul_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .a_i      (in_req_i.multiplicand),
    .b_i      (in_req_i.multiplier),
    .signed_i (is_signed),
    .side_i   (side_in),
    .valid_o  (pipe_valid),
    .ready_i  (pipe_ready),
    .prod_o   (prod),
    .side_o   (side_out)
  );

  assign pipe_ready = !out_valid_q || out_ready_i;
  assign sum        = prod + side_out.addend;

  always_comb begin
    rsp_d.result_low      = sum[31:0];
    rsp_d.flags_written   = side_out.set_flags;
    rsp_d.internal_cycles = side_out.cycles;
    if (side_out.is_long) begin
      rsp_d.result_high   = sum[63:32];
      rsp_d.zero_flag     = side_out.set_flags && (sum == 64'd0);
      rsp_d.negative_flag = side_out.set_flags && sum[63];
    end else begin
      rsp_d.result_high   = 32'd0;
      rsp_d.zero_flag     = side_out.set_flags && (sum[31:0] == 32'd0);
      rsp_d.negative_flag = side_out.set_flags && sum[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_ready) begin
      out_valid_q <= pipe_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready && pipe_valid) begin
      rsp_q  <= rsp_d;
      long_q <= side_out.is_long;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !long_q |-> rsp_q.result_high == 32'd0)
    else $error("short form produced a nonzero high word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rsp_q.internal_cycles != 3'd0 && rsp_q.internal_cycles != 3'd7)
    else $error("internal cycle count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_q.flags_written |-> !rsp_q.zero_flag && !rsp_q.negative_flag)
    else $error("flags raised without a flag request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rsp_q.zero_flag |-> !rsp_q.negative_flag)
    else $error("zero and negative flags both set");

endmodule
